// ----- hdl/duration_string_to_seconds_defines.svh -----
// ----------------------------------------------------------------------------
// Duration string parser assertion macros
// Shared property forms for the checker of the duration string parser.
// ----------------------------------------------------------------------------
`ifndef DURATION_STRING_TO_SECONDS_DEFINES_SVH
`define DURATION_STRING_TO_SECONDS_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define DSTS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("duration parser check failed");

// Next-cycle implication, disabled while in reset
`define DSTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("duration parser check failed");

`endif

// ----- hdl/dsts_pkg.sv -----
// ----------------------------------------------------------------------------
// Duration string parser package
// Item types, status codes, unit characters and unit scale factors.
// ----------------------------------------------------------------------------
package dsts_pkg;

	localparam int unsigned SEC_W  = 31;
	localparam int unsigned MULT_W = 20;
	localparam int unsigned CHAR_W = 8;

	localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

	// Seconds per unit
	localparam logic [MULT_W-1:0] MULT_WEEK = MULT_W'(7 * 24 * 60 * 60);
	localparam logic [MULT_W-1:0] MULT_DAY  = MULT_W'(24 * 60 * 60);
	localparam logic [MULT_W-1:0] MULT_HOUR = MULT_W'(60 * 60);
	localparam logic [MULT_W-1:0] MULT_MIN  = MULT_W'(60);
	localparam logic [MULT_W-1:0] MULT_SEC  = MULT_W'(1);

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
	localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
	localparam logic [CHAR_W-1:0] CH_H     = 8'h68;
	localparam logic [CHAR_W-1:0] CH_M     = 8'h6d;
	localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_MALFORMED = 2'd1,
		ERR_NEGATIVE  = 2'd2,
		ERR_INVALID   = 2'd3
	} err_code_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MALFORMED = 3'd1,
		ST_NEGATIVE  = 3'd2,
		ST_INVALID   = 3'd3,
		ST_TOO_BIG   = 3'd4
	} status_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              has_char;
		logic              end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [SEC_W-1:0] seconds;
		status_t          status;
	} result_t;

endpackage

// ----- hdl/duration_string_to_seconds.sv -----
// ----------------------------------------------------------------------------
// Duration string to seconds
// Parses a w/d/h/m/s duration string, one character per item, into seconds.
// ----------------------------------------------------------------------------
// The block takes one character item per clock and gives one result item,
// seconds and status, for each item that marks the end of a string. A
// character is registered at the input, then in the next cycle a single
// parse stage does the digit accumulate or the constant scale-add (at most
// a 31 by 20 bit constant multiply and one add with saturation) and updates
// the parse state. The result of an end-of-string item goes from the input
// register through the parse stage into the output result register. Items
// flow at one per cycle; the input stalls only while an end-of-string item
// waits behind a result that the consumer has not taken.
module duration_string_to_seconds import dsts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	input  logic        has_char,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] seconds,
	output logic [2:0]  status
);

	in_item_t item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     take;
	logic     fire;
	logic     out_free;
	result_t  result;
	result_t  result_q;

	assign item.character     = character;
	assign item.has_char      = has_char;
	assign item.end_of_string = end_of_string;

	// Advance the held item unless its result has nowhere to go
	assign take = valid_s1 && (!item_s1.end_of_string || out_free);
	assign fire = take;

	dsts_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dsts_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	dsts_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && item_s1.end_of_string),
		.result    (result),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_q  (result_q)
	);

	assign seconds = result_q.seconds;
	assign status  = result_q.status;

endmodule

// ----- hdl/dsts_in_stage.sv -----
// ----------------------------------------------------------------------------
// Duration string parser input stage
// Registers one input item and holds it until the parse stage takes it.
// ----------------------------------------------------------------------------
module dsts_in_stage import dsts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t item,
	input  logic     take,
	output logic     valid_s1,
	output in_item_t item_s1
);

	logic load;

	// Accept when empty or when the held item leaves this cycle
	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the item payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// ----- hdl/dsts_parse.sv -----
// ----------------------------------------------------------------------------
// Duration string parser core
// Parse state and the combinational digit accumulate and unit scale-add.
// ----------------------------------------------------------------------------
module dsts_parse import dsts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  in_item_t item,
	output result_t  result
);

	logic [SEC_W-1:0]   digit_value_q;
	logic               have_digits_q;
	logic [SEC_W-1:0]   total_q;
	err_code_t          err_code_q;
	logic               err_seen_q;
	logic               ovf_seen_q;

	logic [SEC_W-1:0]   digit_value_d;
	logic               have_digits_d;
	logic [SEC_W-1:0]   total_d;
	err_code_t          err_code_d;
	logic               err_seen_d;
	logic               ovf_seen_d;

	logic               num_char;
	logic               unit_hit;
	logic [MULT_W-1:0]  unit_mult;
	logic               take_char;
	logic [SEC_W+3:0]   dig_acc;
	logic               dig_over;
	logic               unit_add;
	logic               tail_add;
	logic [SEC_W+MULT_W-1:0] prod;
	logic [SEC_W+MULT_W-1:0] addend;
	logic [SEC_W+MULT_W:0]   sum;
	logic               sum_over;

	// Classify the character
	assign num_char = (item.character >= CH_0) && (item.character <= CH_9);

	always_comb begin
		unit_hit  = 1'b1;
		unit_mult = MULT_SEC;
		case (item.character)
			CH_W:    unit_mult = MULT_WEEK;
			CH_D:    unit_mult = MULT_DAY;
			CH_H:    unit_mult = MULT_HOUR;
			CH_M:    unit_mult = MULT_MIN;
			CH_S:    unit_mult = MULT_SEC;
			default: unit_hit  = 1'b0;
		endcase
	end

	// Digit accumulate: value * 10 + digit
	assign dig_acc  = (SEC_W+4)'({digit_value_q, 3'b000})
		+ (SEC_W+4)'({digit_value_q, 1'b0})
		+ (SEC_W+4)'(item.character[3:0]);
	assign dig_over = dig_acc > (SEC_W+4)'(SEC_MAX);

	assign take_char = item.has_char && !err_seen_q;
	assign unit_add  = take_char && !num_char && have_digits_q && unit_hit;

	// Next state before any scale-add
	always_comb begin
		digit_value_d = digit_value_q;
		have_digits_d = have_digits_q;
		err_code_d    = err_code_q;
		err_seen_d    = err_seen_q;
		ovf_seen_d    = ovf_seen_q;
		if (take_char) begin
			if (num_char) begin
				digit_value_d = dig_over ? SEC_MAX : dig_acc[SEC_W-1:0];
				have_digits_d = 1'b1;
				if (dig_over) begin
					ovf_seen_d = 1'b1;
				end
			end else if (!have_digits_q) begin
				err_seen_d = 1'b1;
				err_code_d = ERR_MALFORMED;
			end else if (!unit_hit) begin
				err_seen_d = 1'b1;
				err_code_d = (item.character == CH_MINUS) ? ERR_NEGATIVE : ERR_INVALID;
			end
		end
	end

	// Trailing digits at end of string count as seconds
	assign tail_add = item.end_of_string && !err_seen_d && have_digits_d;

	// Scale the held run by the unit, or add trailing digits as they are
	assign prod     = (SEC_W+MULT_W)'(unit_mult) * (SEC_W+MULT_W)'(digit_value_q);
	assign addend   = unit_add ? prod : (SEC_W+MULT_W)'(digit_value_d);
	assign sum      = (SEC_W+MULT_W+1)'(total_q) + (SEC_W+MULT_W+1)'(addend);
	assign sum_over = sum > (SEC_W+MULT_W+1)'(SEC_MAX);

	always_comb begin
		total_d = total_q;
		if (unit_add || tail_add) begin
			total_d = sum_over ? SEC_MAX : sum[SEC_W-1:0];
		end
	end

	// Build the result for an end-of-string item
	always_comb begin
		result.seconds = '0;
		result.status  = ST_OK;
		if (err_seen_d) begin
			result.status = status_t'({1'b0, err_code_d});
		end else if (ovf_seen_d || ((unit_add || tail_add) && sum_over)) begin
			result.status = ST_TOO_BIG;
		end else begin
			result.seconds = total_d;
		end
	end

	// Update state; clear everything after a string ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_value_q <= '0;
			have_digits_q <= 1'b0;
			total_q       <= '0;
			err_code_q    <= ERR_NONE;
			err_seen_q    <= 1'b0;
			ovf_seen_q    <= 1'b0;
		end else if (fire) begin
			if (item.end_of_string) begin
				digit_value_q <= '0;
				have_digits_q <= 1'b0;
				total_q       <= '0;
				err_code_q    <= ERR_NONE;
				err_seen_q    <= 1'b0;
				ovf_seen_q    <= 1'b0;
			end else begin
				digit_value_q <= unit_add ? '0 : digit_value_d;
				have_digits_q <= unit_add ? 1'b0 : have_digits_d;
				total_q       <= total_d;
				err_code_q    <= err_code_d;
				err_seen_q    <= err_seen_d;
				ovf_seen_q    <= ovf_seen_d || (unit_add && sum_over);
			end
		end
	end

endmodule

// ----- hdl/dsts_out_stage.sv -----
// ----------------------------------------------------------------------------
// Duration string parser output stage
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module dsts_out_stage import dsts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	output logic    out_free,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t result_q
);

	// Room for a new item when empty or when the held one is taken now
	assign out_free = !out_valid || !out_stall;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (out_free && load) begin
			result_q <= result;
		end
	end

endmodule

// ----- hdl/dsts_checker.sv -----
// ----------------------------------------------------------------------------
// Duration string parser checker
// Port-level properties of the duration string parser, bound to the top.
// ----------------------------------------------------------------------------
`include "duration_string_to_seconds_defines.svh"

module dsts_checker import dsts_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        end_of_string,
	input logic        out_valid,
	input logic        out_stall,
	input logic [30:0] seconds,
	input logic [2:0]  status
);

	// A stalled result holds
	`DSTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(seconds) && $stable(status))

	// Any failing status reports zero seconds
	`DSTS_ASSERT_IMPL(a_err_zero, out_valid && (status != ST_OK), seconds == '0)

	// Input back-pressure comes only from a blocked result
	`DSTS_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)

	// A new result rises only after an accepted end item passed the input and output registers
	`DSTS_ASSERT_IMPL(a_rise_src, $rose(out_valid), $past(in_valid && !in_stall && end_of_string, 2))

endmodule

bind duration_string_to_seconds dsts_checker u_dsts_checker (.*);
